FILE: src/position_table_with_aging_unit_assert.svh
// Assertion macros for the checker of the position table.
`ifndef POSITION_TABLE_WITH_AGING_UNIT_ASSERT_SVH
`define POSITION_TABLE_WITH_AGING_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTWA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ptwa check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTWA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ptwa check failed");

`endif

FILE: src/ptwa_pkg.sv
package ptwa_pkg;

	localparam int OP_W   = 3;
	localparam int ADDR_W = 32;
	localparam int LOAD_W = 8;
	localparam int STS_W  = 2;

	localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_EXPIRE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
	localparam logic [OP_W-1:0] OP_OLDEST = 3'd5;
	localparam logic [OP_W-1:0] OP_LIST   = 3'd6;

	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL     = 2'd2;
	localparam logic [STS_W-1:0] STS_BADADDR  = 2'd3;

	// Controls broadcast to every cell of the ring.
	typedef struct packed {
		logic shift;
		logic clear;
	} ptwa_cell_ctl_t;

endpackage

FILE: src/ptwa_ifs.sv
interface ptwa_req_if import ptwa_pkg::*; #(
	parameter int TIME_BITS  = 48,
	parameter int COORD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic [OP_W-1:0]              op;
	logic [ADDR_W-1:0]            node_address;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;
	logic [LOAD_W-1:0]            congestion;
	logic [TIME_BITS-1:0]         now_time;
	logic [TIME_BITS-1:0]         cutoff_time;

	modport source (output valid, op, node_address, pos_x, pos_y, pos_z, congestion,
		now_time, cutoff_time, input ready);
	modport sink (input valid, op, node_address, pos_x, pos_y, pos_z, congestion,
		now_time, cutoff_time, output ready);
endinterface

interface ptwa_rsp_if import ptwa_pkg::*; #(
	parameter int TIME_BITS  = 48,
	parameter int COORD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic [STS_W-1:0]             status;
	logic                         found;
	logic [ADDR_W-1:0]            out_address;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic signed [COORD_BITS-1:0] out_z;
	logic [LOAD_W-1:0]            out_congestion;
	logic [TIME_BITS-1:0]         stamp;
	logic                         last;

	modport source (output valid, status, found, out_address, out_x, out_y, out_z,
		out_congestion, stamp, last, input ready);
	modport sink (input valid, status, found, out_address, out_x, out_y, out_z,
		out_congestion, stamp, last, output ready);
endinterface

FILE: src/ptwa_cell.sv
// One slot of the rotating table: takes its neighbor's entry on a shift.
module ptwa_cell import ptwa_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ptwa_cell_ctl_t    ctl,
	input  logic              d_valid,
	input  logic [DATA_W-1:0] d_data,
	output logic              q_valid,
	output logic [DATA_W-1:0] q_data
);

	logic              valid_q;
	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= d_data;
		end
	end

	assign q_valid = valid_q;
	assign q_data  = data_q;

endmodule

FILE: src/position_table_with_aging_unit.sv
// Position table with timestamp aging. The entries live in a ring of
// TABLE_ENTRIES cells that rotates by one slot per cycle while an operation
// scans or fills, except while a list word waits on rsp, so every scanning
// operation looks at one entry per cycle at the head of the ring, in index
// order. A word is taken on req only when the block is idle. Clear, an
// address of zero on write, lookup or remove, and an unused opcode skip the
// rotation and go straight to the final word. Lookup, remove, expire, oldest
// and a write to a present key or to a full table make one rotation. A
// write of a new key needs a second rotation to place it in the lowest free
// slot. List makes one rotation that holds while rsp stalls, and gives
// one word per valid entry, or a single word with found low on an empty
// table; last marks the final word of each operation. The result register
// on rsp lets a new request start while the last result still waits.
module position_table_with_aging_unit import ptwa_pkg::*; #(
	parameter int TABLE_ENTRIES = 16,
	parameter int TIME_BITS     = 48,
	parameter int COORD_BITS    = 32
) (
	input logic     clk,
	input logic     arst_n,
	ptwa_req_if.sink   req,
	ptwa_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0]     key;
		logic [TIME_BITS-1:0]  stamp;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [LOAD_W-1:0]     load;
	} entry_t;

	typedef struct packed {
		logic [STS_W-1:0]      status;
		logic                  found;
		logic [ADDR_W-1:0]     address;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [LOAD_W-1:0]     load;
		logic [TIME_BITS-1:0]  stamp;
		logic                  last;
	} res_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Final words that carry nothing but a status and the last flag.
	localparam res_t RES_END = '{last: 1'b1, default: '0};
	localparam res_t RES_BAD = '{status: STS_BADADDR, last: 1'b1, default: '0};

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [OP_W-1:0]      op_q;
	entry_t               wr_q;
	logic [TIME_BITS-1:0] cut_q;
	logic                 hit_q, free_found_q, any_q, pend_v_q, out_v_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [TIME_BITS-1:0] min_q;
	entry_t               cap_q, pend_q;
	res_t                 res_q, out_q;

	ptwa_cell_ctl_t   ctl;
	logic             cell_v [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] cell_d [TABLE_ENTRIES];
	entry_t           head, nh;
	logic             head_v, nh_v, match, stale;
	logic             accept, can_push, list_stall, last_step;
	logic             hit_n, free_found_n, any_n;
	logic [TIME_BITS-1:0] min_n;
	entry_t           cap_n;
	logic             push;
	res_t             push_data, fin_res;

	// The ring: each cell takes the entry of its upper neighbor, and the top
	// cell takes the head entry after this operation has acted on it.
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		logic             d_v;
		logic [ENTRY_W-1:0] d_d;
		if (i == TABLE_ENTRIES - 1) begin : g_top
			assign d_v = nh_v;
			assign d_d = nh;
		end else begin : g_mid
			assign d_v = cell_v[i+1];
			assign d_d = cell_d[i+1];
		end
		ptwa_cell #(.DATA_W(ENTRY_W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d_valid(d_v),
			.d_data (d_d),
			.q_valid(cell_v[i]),
			.q_data (cell_d[i])
		);
	end

	assign head   = entry_t'(cell_d[0]);
	assign head_v = cell_v[0];
	assign match  = head_v && (head.key == wr_q.key);
	assign stale  = head_v && (head.stamp <= cut_q);

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign can_push  = !out_v_q || rsp.ready;
	assign last_step = (cnt_q == IDX_W'(TABLE_ENTRIES - 1));

	// A listed entry waits in the pending register until the next valid
	// entry shows that it is not the final one.
	assign list_stall = (state_q == S_SCAN) && (op_q == OP_LIST) && head_v &&
		pend_v_q && !can_push;

	assign ctl = '{
		shift: ((state_q == S_SCAN) || (state_q == S_FILL)) && !list_stall,
		clear: accept && (req.op == OP_CLEAR)
	};

	// Effect of the operation on the head entry.
	always_comb begin
		nh   = head;
		nh_v = head_v;
		case (op_q)
			OP_WRITE: begin
				if (state_q == S_SCAN) begin
					if (match) begin
						nh = wr_q;
					end
				end else if (cnt_q == free_idx_q) begin
					nh   = wr_q;
					nh_v = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (match) begin
					nh_v = 1'b0;
				end
			end
			OP_EXPIRE: begin
				if (stale) begin
					nh_v = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Running results of the scan including the entry now at the head.
	always_comb begin
		hit_n        = hit_q || match;
		free_found_n = free_found_q || !head_v;
		any_n        = any_q || head_v;
		min_n        = (head_v && (head.stamp < min_q)) ? head.stamp : min_q;
		cap_n        = match ? head : cap_q;
	end

	// Final word of every operation but list that ends with its scan.
	always_comb begin
		fin_res      = '0;
		fin_res.last = 1'b1;
		case (op_q)
			OP_WRITE: begin
				if (hit_n) begin
					fin_res.found = 1'b1;
				end else begin
					fin_res.status = STS_FULL;
				end
			end
			OP_LOOKUP, OP_REMOVE: begin
				if (hit_n) begin
					fin_res.found = 1'b1;
					if (op_q == OP_LOOKUP) begin
						fin_res.address = cap_n.key;
						fin_res.x       = cap_n.x;
						fin_res.y       = cap_n.y;
						fin_res.z       = cap_n.z;
						fin_res.load    = cap_n.load;
					end
				end else begin
					fin_res.status = STS_NOTFOUND;
				end
			end
			OP_OLDEST: begin
				fin_res.found = any_n;
				fin_res.stamp = min_n;
			end
			default: ;
		endcase
	end

	// Words toward the result register.
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (state_q == S_SCAN && op_q == OP_LIST && head_v && pend_v_q && can_push) begin
			push = 1'b1;
		end else if (state_q == S_DONE && can_push) begin
			push = 1'b1;
		end
		if (op_q == OP_LIST) begin
			if (pend_v_q) begin
				push_data.found   = 1'b1;
				push_data.address = pend_q.key;
				push_data.x       = pend_q.x;
				push_data.y       = pend_q.y;
				push_data.z       = pend_q.z;
				push_data.load    = pend_q.load;
				push_data.stamp   = pend_q.stamp;
			end
			push_data.last = (state_q == S_DONE);
		end else begin
			push_data = res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			op_q         <= '0;
			wr_q         <= '0;
			cut_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			any_q        <= 1'b0;
			min_q        <= '0;
			cap_q        <= '0;
			pend_q       <= '0;
			pend_v_q     <= 1'b0;
			res_q        <= '0;
			out_q        <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (push) begin
				out_q   <= push_data;
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= req.op;
						wr_q         <= '{key: req.node_address, stamp: req.now_time,
							x: req.pos_x, y: req.pos_y, z: req.pos_z, load: req.congestion};
						cut_q        <= req.cutoff_time;
						cnt_q        <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						any_q        <= 1'b0;
						min_q        <= '1;
						cap_q        <= '0;
						pend_v_q     <= 1'b0;
						if ((req.node_address == '0) && ((req.op == OP_WRITE) ||
							(req.op == OP_LOOKUP) || (req.op == OP_REMOVE))) begin
							res_q   <= RES_BAD;
							state_q <= S_DONE;
						end else if ((req.op == OP_CLEAR) || (req.op > OP_LIST)) begin
							res_q   <= RES_END;
							state_q <= S_DONE;
						end else begin
							res_q   <= RES_END;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (ctl.shift) begin
						cnt_q        <= last_step ? '0 : cnt_q + 1'b1;
						hit_q        <= hit_n;
						any_q        <= any_n;
						min_q        <= min_n;
						cap_q        <= cap_n;
						free_found_q <= free_found_n;
						if (!free_found_q && !head_v) begin
							free_idx_q <= cnt_q;
						end
						if (op_q == OP_LIST && head_v) begin
							pend_q   <= head;
							pend_v_q <= 1'b1;
						end
						if (last_step) begin
							res_q <= fin_res;
							if (op_q == OP_WRITE && !hit_n && free_found_n) begin
								state_q <= S_FILL;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_FILL: begin
					cnt_q <= last_step ? '0 : cnt_q + 1'b1;
					if (last_step) begin
						res_q   <= RES_END;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_q.status;
	assign rsp.found          = out_q.found;
	assign rsp.out_address    = out_q.address;
	assign rsp.out_x          = out_q.x;
	assign rsp.out_y          = out_q.y;
	assign rsp.out_z          = out_q.z;
	assign rsp.out_congestion = out_q.load;
	assign rsp.stamp          = out_q.stamp;
	assign rsp.last           = out_q.last;

endmodule

FILE: src/ptwa_chk.sv
`include "position_table_with_aging_unit_assert.svh"

module ptwa_chk import ptwa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [STS_W-1:0] rsp_status,
	input logic             rsp_found,
	input logic             rsp_last
);

	// A request keeps the table busy for at least the next cycle.
	`PTWA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	// A stalled word stays offered.
	`PTWA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	// Rejected addresses never report a hit and end the operation.
	`PTWA_ASSERT_NOW(a_bad_addr, clk, arst_n, rsp_valid && (rsp_status == STS_BADADDR),
		!rsp_found && rsp_last)
	// A full table stores nothing and ends the operation.
	`PTWA_ASSERT_NOW(a_full, clk, arst_n, rsp_valid && (rsp_status == STS_FULL),
		!rsp_found && rsp_last)

endmodule

bind position_table_with_aging_unit ptwa_chk u_ptwa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_status(rsp.status),
	.rsp_found (rsp.found),
	.rsp_last  (rsp.last)
);

FILE: verif/position_table_with_aging_unit_tb.sv
module position_table_with_aging_unit_tb;
	import ptwa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 16;
	localparam int TBITS   = 48;
	localparam int CBITS   = 32;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;

	// One request word as the driver puts it on the req channel.
	typedef struct {
		logic [OP_W-1:0]          op;
		logic [ADDR_W-1:0]        addr;
		logic signed [CBITS-1:0]  x;
		logic signed [CBITS-1:0]  y;
		logic signed [CBITS-1:0]  z;
		logic [LOAD_W-1:0]        load;
		logic [TBITS-1:0]         now_t;
		logic [TBITS-1:0]         cut_t;
	} table_cmd_t;

	// One response word as the table should return it.
	typedef struct {
		logic [STS_W-1:0]         status;
		logic                     found;
		logic [ADDR_W-1:0]        addr;
		logic signed [CBITS-1:0]  x;
		logic signed [CBITS-1:0]  y;
		logic signed [CBITS-1:0]  z;
		logic [LOAD_W-1:0]        load;
		logic [TBITS-1:0]         stamp;
		logic                     last;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ptwa_req_if #(.TIME_BITS(TBITS), .COORD_BITS(CBITS)) req ();
	ptwa_rsp_if #(.TIME_BITS(TBITS), .COORD_BITS(CBITS)) rsp ();

	position_table_with_aging_unit #(
		.TABLE_ENTRIES(ENTRIES),
		.TIME_BITS(TBITS),
		.COORD_BITS(CBITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the table. Key and payload of a slot are only read while
	// the slot is marked valid, just like in the block.
	logic             shadow_valid [ENTRIES];
	logic [ADDR_W-1:0] shadow_key   [ENTRIES];
	logic [TBITS-1:0]  shadow_stamp [ENTRIES];
	logic [CBITS-1:0]  shadow_x     [ENTRIES];
	logic [CBITS-1:0]  shadow_y     [ENTRIES];
	logic [CBITS-1:0]  shadow_z     [ENTRIES];
	logic [LOAD_W-1:0] shadow_load  [ENTRIES];

	table_cmd_t   pending_cmds[$];
	table_reply_t expected_replies[$];

	// Append to the tail of the two queues.
	function automatic void expect_reply(table_reply_t r);
		expected_replies.insert(expected_replies.size(), r);
	endfunction

	function automatic void queue_cmd(table_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Idle profile shared by driver and monitor; the stimulus changes it
	// between phases.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_sender = 1'b0;

	int unsigned error_count = 0;
	int unsigned words_checked = 0;
	int unsigned cmds_sent = 0;
	int unsigned lists_seen = 0;
	int unsigned full_seen = 0;
	longint unsigned cycle_count = 0;

	function automatic table_reply_t blank_reply();
		table_reply_t r;
		r.status = STS_OK;
		r.found  = 1'b0;
		r.addr   = '0;
		r.x      = '0;
		r.y      = '0;
		r.z      = '0;
		r.load   = '0;
		r.stamp  = '0;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic int slot_of(logic [ADDR_W-1:0] key);
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_valid[i] && shadow_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic table_reply_t slot_reply(int s);
		table_reply_t r;
		r = blank_reply();
		r.found = 1'b1;
		r.addr  = shadow_key[s];
		r.x     = shadow_x[s];
		r.y     = shadow_y[s];
		r.z     = shadow_z[s];
		r.load  = shadow_load[s];
		return r;
	endfunction

	// Applies one accepted command to the shadow table and queues the
	// response words it must produce.
	task automatic apply_table_cmd(input table_cmd_t c);
		table_reply_t r;
		int s;
		int n;
		r = blank_reply();
		s = -1;
		n = 0;
		case (c.op)
			OP_WRITE: begin
				if (c.addr == '0) begin
					r.status = STS_BADADDR;
				end else begin
					s = slot_of(c.addr);
					if (s >= 0) begin
						r.found = 1'b1;
					end else begin
						for (int i = ENTRIES - 1; i >= 0; i--)
							if (!shadow_valid[i])
								s = i;
						if (s < 0) begin
							r.status = STS_FULL;
							full_seen++;
						end
					end
					if (s >= 0) begin
						shadow_valid[s] = 1'b1;
						shadow_key[s]   = c.addr;
						shadow_stamp[s] = c.now_t;
						shadow_x[s]     = c.x;
						shadow_y[s]     = c.y;
						shadow_z[s]     = c.z;
						shadow_load[s]  = c.load;
					end
				end
				expect_reply(r);
			end
			OP_LOOKUP, OP_REMOVE: begin
				if (c.addr == '0) begin
					r.status = STS_BADADDR;
				end else begin
					s = slot_of(c.addr);
					if (s < 0) begin
						r.status = STS_NOTFOUND;
					end else if (c.op == OP_LOOKUP) begin
						r = slot_reply(s);
					end else begin
						shadow_valid[s] = 1'b0;
						r.found = 1'b1;
					end
				end
				expect_reply(r);
			end
			OP_EXPIRE: begin
				for (int i = 0; i < ENTRIES; i++)
					if (shadow_valid[i] && shadow_stamp[i] <= c.cut_t)
						shadow_valid[i] = 1'b0;
				expect_reply(r);
			end
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					shadow_valid[i] = 1'b0;
				expect_reply(r);
			end
			OP_OLDEST: begin
				r.stamp = '1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (shadow_valid[i]) begin
						r.found = 1'b1;
						if (shadow_stamp[i] < r.stamp)
							r.stamp = shadow_stamp[i];
					end
				end
				expect_reply(r);
			end
			OP_LIST: begin
				lists_seen++;
				for (int i = 0; i < ENTRIES; i++)
					if (shadow_valid[i])
						n++;
				if (n == 0)
					expect_reply(r);
				for (int i = 0; i < ENTRIES; i++) begin
					if (shadow_valid[i]) begin
						r = slot_reply(i);
						r.stamp = shadow_stamp[i];
						n--;
						r.last = (n == 0);
						expect_reply(r);
					end
				end
			end
			default: expect_reply(r);
		endcase
	endtask

	// Driver: presents the head of the pending queue and keeps it until it is
	// accepted. Only one nonblocking assignment per signal per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid        <= 1'b0;
			req.op           <= '0;
			req.node_address <= '0;
			req.pos_x        <= '0;
			req.pos_y        <= '0;
			req.pos_z        <= '0;
			req.congestion   <= '0;
			req.now_time     <= '0;
			req.cutoff_time  <= '0;
		end else begin
			automatic bit taken = req.valid && req.ready;
			automatic bit busy_word = req.valid && !taken;
			if (taken) begin
				apply_table_cmd(pending_cmds.pop_front());
				cmds_sent++;
			end
			if (!busy_word) begin
				if (pending_cmds.size() > 0 && !hold_sender &&
						$urandom_range(99, 0) >= send_idle_pct) begin
					req.valid        <= 1'b1;
					req.op           <= pending_cmds[0].op;
					req.node_address <= pending_cmds[0].addr;
					req.pos_x        <= pending_cmds[0].x;
					req.pos_y        <= pending_cmds[0].y;
					req.pos_z        <= pending_cmds[0].z;
					req.congestion   <= pending_cmds[0].load;
					req.now_time     <= pending_cmds[0].now_t;
					req.cutoff_time  <= pending_cmds[0].cut_t;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls rsp at random and checks every accepted word against
	// the oldest expectation, field by field.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					$error("response word with nothing expected");
					error_count++;
				end else begin
					automatic table_reply_t e = expected_replies.pop_front();
					words_checked++;
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						error_count++;
					end
					if (rsp.found !== e.found) begin
						$error("found: expected %0d, got %0d", e.found, rsp.found);
						error_count++;
					end
					if (rsp.out_address !== e.addr) begin
						$error("out_address: expected %h, got %h", e.addr, rsp.out_address);
						error_count++;
					end
					if (rsp.out_x !== e.x) begin
						$error("out_x: expected %h, got %h", e.x, rsp.out_x);
						error_count++;
					end
					if (rsp.out_y !== e.y) begin
						$error("out_y: expected %h, got %h", e.y, rsp.out_y);
						error_count++;
					end
					if (rsp.out_z !== e.z) begin
						$error("out_z: expected %h, got %h", e.z, rsp.out_z);
						error_count++;
					end
					if (rsp.out_congestion !== e.load) begin
						$error("out_congestion: expected %h, got %h", e.load,
							rsp.out_congestion);
						error_count++;
					end
					if (rsp.stamp !== e.stamp) begin
						$error("stamp: expected %h, got %h", e.stamp, rsp.stamp);
						error_count++;
					end
					if (rsp.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, rsp.last);
						error_count++;
					end
				end
			end
			rsp.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// A small key pool makes hits, overwrites and a full table likely.
	logic [ADDR_W-1:0] key_pool [20];
	logic [TBITS-1:0]  clock_now = '0;

	function automatic table_cmd_t make_cmd(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
		table_cmd_t c;
		c.op    = op;
		c.addr  = addr;
		c.x     = $urandom();
		c.y     = $urandom();
		c.z     = $urandom();
		c.load  = LOAD_W'($urandom_range(255, 0));
		c.now_t = TBITS'({$urandom(), $urandom()});
		c.cut_t = TBITS'({$urandom(), $urandom()});
		return c;
	endfunction

	// Random command with a mostly advancing clock, so expire and oldest see
	// realistic aging. Occasionally keys and times are fully random.
	function automatic table_cmd_t random_cmd();
		table_cmd_t c;
		int pick;
		logic [OP_W-1:0] op;
		pick = $urandom_range(99, 0);
		if (pick < 38)      op = OP_WRITE;
		else if (pick < 58) op = OP_LOOKUP;
		else if (pick < 70) op = OP_REMOVE;
		else if (pick < 78) op = OP_EXPIRE;
		else if (pick < 81) op = OP_CLEAR;
		else if (pick < 88) op = OP_OLDEST;
		else if (pick < 97) op = OP_LIST;
		else                op = OP_UNUSED;
		c = make_cmd(op, key_pool[$urandom_range(19, 0)]);
		if ($urandom_range(19, 0) == 0)
			c.addr = $urandom();
		else if ($urandom_range(29, 0) == 0)
			c.addr = '0;
		clock_now = clock_now + TBITS'($urandom_range(1000, 1));
		if ($urandom_range(9, 0) != 0) begin
			c.now_t = clock_now;
			c.cut_t = clock_now - TBITS'($urandom_range(20000, 0));
		end
		return c;
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_replies.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		table_cmd_t c;
		arst_n = 1'b0;
		for (int i = 0; i < 20; i++)
			key_pool[i] = (i == 19) ? 32'hFFFF_FFFF : $urandom() | 32'h1;
		for (int i = 0; i < ENTRIES; i++)
			shadow_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// Directed part: empty-table behavior, address zero, extremes of
		// every field, overwrite, a full table and the unused opcode.
		queue_cmd(make_cmd(OP_LIST, 32'd1));
		c = make_cmd(OP_OLDEST, 32'd1);
		queue_cmd(c);
		queue_cmd(make_cmd(OP_REMOVE, 32'd5));
		queue_cmd(make_cmd(OP_LOOKUP, 32'd5));
		queue_cmd(make_cmd(OP_WRITE, 32'd0));
		queue_cmd(make_cmd(OP_LOOKUP, 32'd0));
		queue_cmd(make_cmd(OP_REMOVE, 32'd0));
		c = make_cmd(OP_WRITE, 32'hFFFF_FFFF);
		c.x = 32'sh8000_0000; c.y = 32'sh7FFF_FFFF; c.z = -1; c.load = 8'hFF;
		c.now_t = '1;
		queue_cmd(c);
		c = make_cmd(OP_WRITE, 32'd1);
		c.x = '0; c.y = '0; c.z = '0; c.load = '0; c.now_t = '0;
		queue_cmd(c);
		queue_cmd(make_cmd(OP_LOOKUP, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(OP_OLDEST, 32'd1));
		queue_cmd(make_cmd(OP_WRITE, 32'd1));
		queue_cmd(make_cmd(OP_LOOKUP, 32'd1));
		for (int i = 2; i < ENTRIES + 2; i++)
			queue_cmd(make_cmd(OP_WRITE, 32'h100 + i));
		queue_cmd(make_cmd(OP_LIST, 32'd1));
		queue_cmd(make_cmd(OP_REMOVE, 32'h103));
		queue_cmd(make_cmd(OP_WRITE, 32'h200));
		c = make_cmd(OP_EXPIRE, 32'd1);
		c.cut_t = '0;
		queue_cmd(c);
		c = make_cmd(OP_EXPIRE, 32'd1);
		queue_cmd(c);
		queue_cmd(make_cmd(OP_UNUSED, 32'd9));
		queue_cmd(make_cmd(OP_CLEAR, 32'd1));
		queue_cmd(make_cmd(OP_LIST, 32'd1));
		c = make_cmd(OP_EXPIRE, 32'd1);
		c.cut_t = '1;
		queue_cmd(c);
		wait_drained();

		// The sender pauses here until every expected word has arrived.
		hold_sender = 1'b1;
		wait_drained();
		hold_sender = 1'b0;

		// Random phases with different idle profiles, the first and last with none.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int k = 0; k < 56; k++)
				queue_cmd(random_cmd());
			wait_drained();
		end

		repeat (3 * ENTRIES + 10) @(posedge clk);
		$display("Ran %0d commands and checked %0d response words (%0d lists, %0d full-table writes).",
			cmds_sent, words_checked, lists_seen, full_seen);
		if (error_count == 0 && expected_replies.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: position_table_with_aging_unit.f
+incdir+src
src/ptwa_pkg.sv
src/ptwa_ifs.sv
src/ptwa_cell.sv
src/position_table_with_aging_unit.sv
src/ptwa_chk.sv
verif/position_table_with_aging_unit_tb.sv
